### src/bale_pkg.sv
// Shared constants, codes and types of the bounded array list engine.
`default_nettype none

package bale_pkg;

	// List geometry.
	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);

	// Field widths of a transaction.
	localparam int ACTION_W = 4;
	localparam int COUNT_W  = 7;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 2;

	// Action codes.
	localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 4'd0;
	localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 4'd1;
	localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 4'd2;
	localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 4'd3;
	localparam logic [ACTION_W-1:0] ACT_INSERT     = 4'd4;
	localparam logic [ACTION_W-1:0] ACT_ERASE      = 4'd5;
	localparam logic [ACTION_W-1:0] ACT_READ       = 4'd6;
	localparam logic [ACTION_W-1:0] ACT_WRITE      = 4'd7;
	localparam logic [ACTION_W-1:0] ACT_CLEAR      = 4'd8;
	localparam logic [ACTION_W-1:0] ACT_RESIZE     = 4'd9;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	// Port request from the sequencer to the element memory.
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [WORD_W-1:0] wdata;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	// Finished result handed from the sequencer to the output register.
	typedef struct packed {
		logic                load;
		logic [WORD_W-1:0]   read_word;
		logic [COUNT_W-1:0]  count;
		logic [STATUS_W-1:0] status;
	} res_t;

endpackage

`default_nettype wire

### src/bale_ram.sv
// Generic single-write, single-read memory with a registered read port.
`default_nettype none

module bale_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### src/bale_ctrl.sv
// Sequencer of the list engine: decodes a transaction and moves elements one per cycle.
`default_nettype none

module bale_ctrl import bale_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [ACTION_W-1:0] action,
	input  wire logic [COUNT_W-1:0]  position,
	input  wire logic [WORD_W-1:0]   word,
	input  wire logic                out_free,
	input  wire logic [WORD_W-1:0]   ram_rdata,
	output ram_req_t                 ram_req,
	output res_t                     res
);

	// Sequencer states.
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_MOVE   = 3'd1;
	localparam logic [2:0] S_DRAIN  = 3'd2;
	localparam logic [2:0] S_TAIL   = 3'd3;
	localparam logic [2:0] S_FILL   = 3'd4;
	localparam logic [2:0] S_READ   = 3'd5;
	localparam logic [2:0] S_FINISH = 3'd6;

	logic [2:0]          state_q, state_d;
	logic [COUNT_W-1:0]  count_q, count_d;
	logic [ADDR_W-1:0]   cur_q, cur_d;
	logic [ADDR_W-1:0]   last_q, last_d;
	logic                dir_up_q, dir_up_d;
	logic                tail_q, tail_d;
	logic [ADDR_W-1:0]   tail_addr_q, tail_addr_d;
	logic                pend_q, pend_d;
	logic [ADDR_W-1:0]   pend_addr_q, pend_addr_d;
	logic [WORD_W-1:0]   word_q, word_d;
	logic [STATUS_W-1:0] status_q, status_d;
	logic [WORD_W-1:0]   rd_q, rd_d;

	logic                accept;
	logic                now_done;
	logic                full;
	logic [COUNT_W-1:0]  cnt_m1;
	logic [COUNT_W-1:0]  pos_m1;
	logic [COUNT_W-1:0]  ins_pos;
	logic [COUNT_W-1:0]  era_pos;
	logic [COUNT_W-1:0]  era_p1;

	assign in_stall = (state_q != S_IDLE) || !out_free;
	assign accept   = in_valid && !in_stall;
	assign full     = (count_q == COUNT_W'(CAPACITY));
	assign cnt_m1   = count_q - COUNT_W'(1);
	assign pos_m1   = position - COUNT_W'(1);

	// Push front is an insert at the head, pop front an erase at the head.
	assign ins_pos = (action == ACT_PUSH_FRONT) ? '0 : position;
	assign era_pos = (action == ACT_POP_FRONT) ? '0 : position;
	assign era_p1  = era_pos + COUNT_W'(1);

	// Decode, element moves and result hand-off.
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		cur_d       = cur_q;
		last_d      = last_q;
		dir_up_d    = dir_up_q;
		tail_d      = tail_q;
		tail_addr_d = tail_addr_q;
		pend_d      = pend_q;
		pend_addr_d = pend_addr_q;
		word_d      = word_q;
		status_d    = status_q;
		rd_d        = rd_q;
		now_done    = 1'b0;
		ram_req     = '0;
		ram_req.raddr = cur_q;
		res         = '0;

		unique case (state_q)
			S_IDLE: begin
				ram_req.raddr = position[ADDR_W-1:0];
				if (accept) begin
					status_d = ST_DONE;
					rd_d     = '0;
					word_d   = word;
					unique case (action)
						ACT_PUSH_BACK: begin
							now_done = 1'b1;
							if (full) begin
								status_d = ST_FULL;
							end else begin
								ram_req.we    = 1'b1;
								ram_req.waddr = count_q[ADDR_W-1:0];
								ram_req.wdata = word;
								count_d       = count_q + COUNT_W'(1);
							end
						end
						ACT_PUSH_FRONT, ACT_INSERT: begin
							if (ins_pos > count_q) begin
								status_d = ST_RANGE;
								now_done = 1'b1;
							end else if (full) begin
								status_d = ST_FULL;
								now_done = 1'b1;
							end else begin
								count_d = count_q + COUNT_W'(1);
								if (ins_pos == count_q) begin
									ram_req.we    = 1'b1;
									ram_req.waddr = ins_pos[ADDR_W-1:0];
									ram_req.wdata = word;
									now_done      = 1'b1;
								end else begin
									cur_d       = cnt_m1[ADDR_W-1:0];
									last_d      = ins_pos[ADDR_W-1:0];
									dir_up_d    = 1'b1;
									tail_d      = 1'b1;
									tail_addr_d = ins_pos[ADDR_W-1:0];
									pend_d      = 1'b0;
									state_d     = S_MOVE;
								end
							end
						end
						ACT_POP_BACK: begin
							now_done = 1'b1;
							if (count_q == '0) begin
								status_d = ST_RANGE;
							end else begin
								count_d = cnt_m1;
							end
						end
						ACT_POP_FRONT, ACT_ERASE: begin
							if (era_pos >= count_q) begin
								status_d = ST_RANGE;
								now_done = 1'b1;
							end else begin
								count_d = cnt_m1;
								if (era_pos == cnt_m1) begin
									now_done = 1'b1;
								end else begin
									cur_d    = era_p1[ADDR_W-1:0];
									last_d   = cnt_m1[ADDR_W-1:0];
									dir_up_d = 1'b0;
									tail_d   = 1'b0;
									pend_d   = 1'b0;
									state_d  = S_MOVE;
								end
							end
						end
						ACT_READ: begin
							if (position >= count_q) begin
								status_d = ST_RANGE;
								now_done = 1'b1;
							end else begin
								state_d = S_READ;
							end
						end
						ACT_WRITE: begin
							now_done = 1'b1;
							if (position >= count_q) begin
								status_d = ST_RANGE;
							end else begin
								ram_req.we    = 1'b1;
								ram_req.waddr = position[ADDR_W-1:0];
								ram_req.wdata = word;
							end
						end
						ACT_CLEAR: begin
							now_done = 1'b1;
							count_d  = '0;
						end
						ACT_RESIZE: begin
							if (position > COUNT_W'(CAPACITY)) begin
								status_d = ST_RANGE;
								now_done = 1'b1;
							end else begin
								count_d = position;
								if (position > count_q) begin
									cur_d   = count_q[ADDR_W-1:0];
									last_d  = pos_m1[ADDR_W-1:0];
									state_d = S_FILL;
								end else begin
									now_done = 1'b1;
								end
							end
						end
						default: begin
							now_done = 1'b1;
						end
					endcase
				end
			end
			S_MOVE: begin
				// Read the next source while writing the previous one to its new place.
				ram_req.raddr = cur_q;
				ram_req.we    = pend_q;
				ram_req.waddr = pend_addr_q;
				ram_req.wdata = ram_rdata;
				pend_d        = 1'b1;
				pend_addr_d   = dir_up_q ? (cur_q + ADDR_W'(1)) : (cur_q - ADDR_W'(1));
				if (cur_q == last_q) begin
					state_d = S_DRAIN;
				end else begin
					cur_d = dir_up_q ? (cur_q - ADDR_W'(1)) : (cur_q + ADDR_W'(1));
				end
			end
			S_DRAIN: begin
				ram_req.we    = pend_q;
				ram_req.waddr = pend_addr_q;
				ram_req.wdata = ram_rdata;
				pend_d        = 1'b0;
				state_d       = tail_q ? S_TAIL : S_FINISH;
			end
			S_TAIL: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = tail_addr_q;
				ram_req.wdata = word_q;
				state_d       = S_FINISH;
			end
			S_FILL: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = cur_q;
				ram_req.wdata = word_q;
				if (cur_q == last_q) begin
					state_d = S_FINISH;
				end else begin
					cur_d = cur_q + ADDR_W'(1);
				end
			end
			S_READ: begin
				rd_d    = ram_rdata;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					res.load      = 1'b1;
					res.status    = status_q;
					res.read_word = rd_q;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// Transactions that finish as they are accepted hand their result over at once.
		if (accept && now_done) begin
			res.load      = 1'b1;
			res.status    = status_d;
			res.read_word = '0;
		end
		res.count = count_d;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pend_q  <= pend_d;
		end
	end

	// Cursors and staged payload.
	always_ff @(posedge clk) begin
		cur_q       <= cur_d;
		last_q      <= last_d;
		dir_up_q    <= dir_up_d;
		tail_q      <= tail_d;
		tail_addr_q <= tail_addr_d;
		pend_addr_q <= pend_addr_d;
		word_q      <= word_d;
		status_q    <= status_d;
		rd_q        <= rd_d;
	end

endmodule

`default_nettype wire

### src/bounded_array_list_engine_core.sv
// Top level of the bounded array list engine: sequencer, element memory and output register.
`default_nettype none

// A fixed-capacity ordered list of up to CAPACITY 32-bit words, kept in one
// memory with one write and one registered read port. Every transaction gives
// exactly one result. Push back, pop back, write, clear, resize that shrinks,
// an insert or push front that lands at the end of the list, an erase or pop
// front of the last element and rejected requests finish as they are
// accepted; a read passes through a read state and a finish state. Any other
// insert or push front shifts the elements from the position on, any other
// erase or pop front shifts the elements behind the position, and a growing
// resize fills the new elements, one element at a time through the single
// memory port, before the result is handed over. The input is stalled while a
// transaction is in progress, and while a finished result still waits in
// the output register with no room for the next one.
module bounded_array_list_engine_core import bale_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [ACTION_W-1:0] action,
	input  wire logic [COUNT_W-1:0]  position,
	input  wire logic [WORD_W-1:0]   word,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [WORD_W-1:0]        read_word,
	output logic [COUNT_W-1:0]       count,
	output logic                     is_empty,
	output logic                     is_full,
	output logic [STATUS_W-1:0]      status
);

	ram_req_t            ram_req;
	res_t                res;
	logic [WORD_W-1:0]   ram_rdata;
	logic                out_free;
	logic                out_valid_q;
	logic [WORD_W-1:0]   read_word_q;
	logic [COUNT_W-1:0]  count_q;
	logic                is_empty_q;
	logic                is_full_q;
	logic [STATUS_W-1:0] status_q;

	assign out_free = !out_valid_q || !out_stall;

	// Sequencer.
	bale_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.position  (position),
		.word      (word),
		.out_free  (out_free),
		.ram_rdata (ram_rdata),
		.ram_req   (ram_req),
		.res       (res)
	);

	// Element memory.
	bale_ram #(
		.WIDTH (WORD_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (res.load) begin
			read_word_q <= res.read_word;
			count_q     <= res.count;
			is_empty_q  <= (res.count == '0);
			is_full_q   <= (res.count == COUNT_W'(CAPACITY));
			status_q    <= res.status;
		end
	end

	assign out_valid = out_valid_q;
	assign read_word = read_word_q;
	assign count     = count_q;
	assign is_empty  = is_empty_q;
	assign is_full   = is_full_q;
	assign status    = status_q;

`ifndef SYNTHESIS
	// A result is only loaded when the output register has room for it.
	a_load_room: assert property (@(posedge clk) disable iff (!arst_n)
		res.load |-> (!out_valid_q || !out_stall))
		else $error("result loaded over a waiting transaction");

	// The count never exceeds the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (count <= COUNT_W'(CAPACITY)))
		else $error("count above capacity");

	// A rejected push leaves the list full.
	a_full_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_FULL)) |-> is_full)
		else $error("full status on a list that is not full");

	// Only a successful read returns a nonzero word.
	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (read_word != '0)) |-> (status == ST_DONE))
		else $error("read word returned with a failing status");
`endif

endmodule

`default_nettype wire
